// File: rtl/stt_pkg.sv
`default_nettype none

package stt_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_QUOTED  = 3'd2,
        MODE_ESCAPE  = 3'd3,
        MODE_BARE    = 3'd4
    } mode_t;

    localparam logic [2:0] KIND_BYTE  = 3'd0;
    localparam logic [2:0] KIND_END   = 3'd1;
    localparam logic [2:0] KIND_COLON = 3'd2;
    localparam logic [2:0] KIND_SEMI  = 3'd3;
    localparam logic [2:0] KIND_LBR   = 3'd4;
    localparam logic [2:0] KIND_RBR   = 3'd5;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] token_byte;
        logic       last;
    } result_t;

    typedef struct packed {
        logic    emit;
        result_t res;
        mode_t   mode;
        logic    quote;
    } start_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c == CH_COLON) || (c == CH_SEMI) || (c == CH_LBRACE) || (c == CH_RBRACE);
    endfunction

    function automatic logic [2:0] punct_kind(input logic [7:0] c);
        logic [2:0] k;
        case (c)
            CH_COLON:  k = KIND_COLON;
            CH_SEMI:   k = KIND_SEMI;
            CH_LBRACE: k = KIND_LBR;
            default:   k = KIND_RBR;
        endcase
        return k;
    endfunction

    // Handling of a byte that arrives between tokens.
    function automatic start_t start_token(input logic [7:0] c, input logic quote_cur);
        start_t s;
        s.emit           = 1'b0;
        s.res.kind       = KIND_BYTE;
        s.res.token_byte = 8'h00;
        s.res.last       = 1'b0;
        s.mode           = MODE_IDLE;
        s.quote          = quote_cur;
        if (is_space(c) || (c == CH_COMMA)) begin
            s.mode = MODE_IDLE;
        end else if (c == CH_HASH) begin
            s.mode = MODE_COMMENT;
        end else if (is_punct(c)) begin
            s.emit     = 1'b1;
            s.res.kind = punct_kind(c);
        end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
            s.quote = (c == CH_SQUOTE);
            s.mode  = MODE_QUOTED;
        end else begin
            s.emit           = 1'b1;
            s.res.token_byte = c;
            s.mode           = MODE_BARE;
        end
        return s;
    endfunction

endpackage

`default_nettype wire

// File: rtl/spec_text_tokenizer_core.sv
// Channel   Direction  Ports                                   Moves
// s_        in         s_valid s_ready s_in_byte s_end_of_input  one text byte or end mark
// m_        out        m_valid m_ready m_kind m_token_byte m_last one token result
//
// A word is lexed in the cycle it is accepted; its results enter a three-entry result
// queue and leave one per cycle while m_ready is high, so the rate is one word per
// cycle, less when m_ready stalls or a word ends an unquoted string with punctuation.
// The input is ready while the queue holds at most one result.
// Synchronous reset empties the queue and returns the lexer to idle between tokens.
`default_nettype none

module spec_text_tokenizer_core
    import stt_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_in_byte,
    input  wire logic       s_end_of_input,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [2:0]      m_kind,
    output logic [7:0]      m_token_byte,
    output logic            m_last
);

    localparam int QDepth = 3;

    mode_t      mode_reg, mode_next;
    logic       quote_reg, quote_next;
    result_t    q_reg  [QDepth];
    result_t    q_next [QDepth];
    logic [1:0] count_reg, count_next;

    logic [1:0] n_res;
    result_t    r0, r1;
    start_t     st;
    logic       push, pop;
    logic [1:0] base;
    logic [7:0] close_ch;

    assign s_ready      = (count_reg <= 2'd1);
    assign m_valid      = (count_reg != 2'd0);
    assign m_kind       = q_reg[0].kind;
    assign m_token_byte = q_reg[0].token_byte;
    assign m_last       = q_reg[0].last;

    assign push = s_valid && s_ready;
    assign pop  = m_valid && m_ready;

    // Lexer step for the word at the input.
    always_comb begin
        n_res      = 2'd0;
        r0         = '{kind: KIND_BYTE, token_byte: 8'h00, last: 1'b1};
        r1         = '{kind: KIND_BYTE, token_byte: 8'h00, last: 1'b1};
        mode_next  = mode_reg;
        quote_next = quote_reg;
        close_ch   = quote_reg ? CH_SQUOTE : CH_DQUOTE;
        st         = start_token(s_in_byte, quote_reg);
        if (s_end_of_input) begin
            if ((mode_reg == MODE_QUOTED) || (mode_reg == MODE_ESCAPE) ||
                (mode_reg == MODE_BARE)) begin
                n_res   = 2'd1;
                r0.kind = KIND_END;
            end
            mode_next = MODE_IDLE;
        end else begin
            unique case (mode_reg)
                MODE_COMMENT: begin
                    if (s_in_byte == CH_LF) mode_next = MODE_IDLE;
                end
                MODE_QUOTED: begin
                    if (s_in_byte == close_ch) begin
                        n_res     = 2'd1;
                        r0.kind   = KIND_END;
                        mode_next = MODE_IDLE;
                    end else if (s_in_byte == CH_BSLASH) begin
                        mode_next = MODE_ESCAPE;
                    end else begin
                        n_res         = 2'd1;
                        r0.token_byte = s_in_byte;
                    end
                end
                MODE_ESCAPE: begin
                    n_res         = 2'd1;
                    r0.token_byte = s_in_byte;
                    mode_next     = MODE_QUOTED;
                end
                MODE_BARE: begin
                    if (is_space(s_in_byte) || is_punct(s_in_byte) ||
                        (s_in_byte == CH_COMMA) || (s_in_byte == CH_HASH) ||
                        (s_in_byte == CH_DQUOTE) || (s_in_byte == CH_SQUOTE)) begin
                        // String end, then whatever the terminating byte starts.
                        r0.kind    = KIND_END;
                        r0.last    = !st.emit;
                        r1         = st.res;
                        r1.last    = 1'b1;
                        n_res      = st.emit ? 2'd2 : 2'd1;
                        mode_next  = st.mode;
                        quote_next = st.quote;
                    end else begin
                        n_res         = 2'd1;
                        r0.token_byte = s_in_byte;
                    end
                end
                default: begin
                    r0         = st.res;
                    r0.last    = 1'b1;
                    n_res      = st.emit ? 2'd1 : 2'd0;
                    mode_next  = st.mode;
                    quote_next = st.quote;
                end
            endcase
        end
    end

    // Result queue: head at entry 0, shifts down on each taken result.
    always_comb begin
        base = count_reg - {1'b0, pop};
        for (int i = 0; i < QDepth; i++) q_next[i] = q_reg[i];
        if (pop) begin
            for (int i = 0; i < QDepth - 1; i++) q_next[i] = q_reg[i + 1];
        end
        for (int i = 0; i < QDepth; i++) begin
            if (push && (n_res != 2'd0) && (base == 2'(i))) q_next[i] = r0;
            if (push && (n_res == 2'd2) && ((base + 2'd1) == 2'(i))) q_next[i] = r1;
        end
        count_next = count_reg - {1'b0, pop} + (push ? n_res : 2'd0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            quote_reg <= 1'b0;
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                mode_reg  <= mode_next;
                quote_reg <= quote_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QDepth; i++) q_reg[i] <= q_next[i];
    end

    // The second result of a word is already queued when the first leaves.
    a_second_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !m_last |=> m_valid)
        else $error("second result of a word missing");

    a_eoi_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_end_of_input |=> mode_reg == MODE_IDLE)
        else $error("lexer not idle after end of input");

    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_kind != KIND_BYTE) |-> m_token_byte == 8'h00)
        else $error("nonzero byte on a non-byte token");

    a_no_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        !pop && !push && m_valid |=> m_valid && $stable(m_kind) && $stable(m_token_byte))
        else $error("queued result changed without a handshake");

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import stt_pkg::*;

    localparam int         PREDICT   = -1;
    localparam logic [2:0] NO_PUNCT  = 3'd7;
    localparam int         TEXT_LEN  = 1350;

    typedef struct {
        logic [7:0] ch;
        logic       eoi;
        int         n_res;
        result_t    r0;
        result_t    r1;
    } word_t;

    logic       aclk = 1'b0;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_byte;
    logic       s_end_of_input;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [2:0] m_kind;
    logic [7:0] m_token_byte;
    logic       m_last;

    spec_text_tokenizer_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_in_byte      (s_in_byte),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_token_byte   (m_token_byte),
        .m_last         (m_last)
    );

    always #10 aclk = ~aclk;

    // Lexer state as the predictor sees it.
    mode_t   lex_state    = MODE_IDLE;
    logic    quote_single = 1'b0;
    result_t step_q[$];
    result_t token_q[$];
    word_t   text_q[$];
    word_t   cur_word;

    int errors      = 0;
    int n_words     = 0;
    int n_eoi       = 0;
    int n_bytes     = 0;
    int n_ends      = 0;
    int n_punct     = 0;
    int stall_left  = 0;
    logic sink_calm = 1'b0;
    logic drv_calm  = 1'b0;

    function automatic logic blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
    endfunction

    function automatic logic [2:0] punct_code(input logic [7:0] c);
        case (c)
            CH_COLON:  return KIND_COLON;
            CH_SEMI:   return KIND_SEMI;
            CH_LBRACE: return KIND_LBR;
            CH_RBRACE: return KIND_RBR;
            default:   return NO_PUNCT;
        endcase
    endfunction

    function automatic logic ends_bare(input logic [7:0] c);
        return blank(c) || (c == CH_COMMA) || (c == CH_HASH) || (c == CH_DQUOTE) ||
               (c == CH_SQUOTE) || (punct_code(c) != NO_PUNCT);
    endfunction

    function void emit(input logic [2:0] k, input logic [7:0] b);
        result_t r;
        r.kind       = k;
        r.token_byte = (k == KIND_BYTE) ? b : 8'h00;
        r.last       = 1'b0;
        step_q.push_back(r);
    endfunction

    function void begin_token(input logic [7:0] c);
        if (blank(c) || (c == CH_COMMA)) begin
            lex_state = MODE_IDLE;
        end else if (c == CH_HASH) begin
            lex_state = MODE_COMMENT;
        end else if (punct_code(c) != NO_PUNCT) begin
            emit(punct_code(c), 8'h00);
            lex_state = MODE_IDLE;
        end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
            quote_single = (c == CH_SQUOTE);
            lex_state    = MODE_QUOTED;
        end else begin
            emit(KIND_BYTE, c);
            lex_state = MODE_BARE;
        end
    endfunction

    // Works out the results of one word into step_q and advances the lexer.
    function void lex_word(input logic [7:0] c, input logic eoi);
        result_t r;
        step_q.delete();
        if (eoi) begin
            if ((lex_state == MODE_QUOTED) || (lex_state == MODE_ESCAPE) ||
                (lex_state == MODE_BARE))
                emit(KIND_END, 8'h00);
            lex_state = MODE_IDLE;
        end else begin
            case (lex_state)
                MODE_COMMENT: begin
                    if (c == CH_LF)
                        lex_state = MODE_IDLE;
                end
                MODE_QUOTED: begin
                    if (c == (quote_single ? CH_SQUOTE : CH_DQUOTE)) begin
                        emit(KIND_END, 8'h00);
                        lex_state = MODE_IDLE;
                    end else if (c == CH_BSLASH) begin
                        lex_state = MODE_ESCAPE;
                    end else begin
                        emit(KIND_BYTE, c);
                    end
                end
                MODE_ESCAPE: begin
                    emit(KIND_BYTE, c);
                    lex_state = MODE_QUOTED;
                end
                MODE_BARE: begin
                    if (ends_bare(c)) begin
                        emit(KIND_END, 8'h00);
                        begin_token(c);
                    end else begin
                        emit(KIND_BYTE, c);
                    end
                end
                default: begin_token(c);
            endcase
        end
        if (step_q.size() > 0) begin
            r = step_q.pop_back();
            r.last = 1'b1;
            step_q.push_back(r);
        end
    endfunction

    // A row of the text; n is the number of typed results, or PREDICT.
    function automatic word_t row(input logic [7:0] ch, input logic eoi, input int n,
                                  input logic [2:0] k0 = KIND_BYTE,
                                  input logic [7:0] b0 = 8'h00,
                                  input logic [2:0] k1 = KIND_BYTE);
        word_t w;
        w.ch    = ch;
        w.eoi   = eoi;
        w.n_res = n;
        w.r0    = '{kind: k0, token_byte: b0, last: (n == 1)};
        w.r1    = '{kind: k1, token_byte: 8'h00, last: 1'b1};
        return w;
    endfunction

    task add(input logic [7:0] ch, input logic eoi);
        text_q.push_back(row(ch, eoi, PREDICT));
    endtask

    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Mostly well-formed property-list text, with some raw noise and broken pieces.
    task build_random_text();
        int r;
        int len;
        logic [7:0] c;
        logic [7:0] q;
        while (text_q.size() < TEXT_LEN + 29) begin
            r = $urandom_range(0, 99);
            if (r < 12) begin
                case ($urandom_range(0, 3))
                    0: add(CH_COLON, 1'b0);
                    1: add(CH_SEMI, 1'b0);
                    2: add(CH_LBRACE, 1'b0);
                    default: add(CH_RBRACE, 1'b0);
                endcase
            end else if (r < 30) begin
                q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                add(q, 1'b0);
                len = $urandom_range(0, 8);
                repeat (len) begin
                    c = 8'($urandom_range(0, 255));
                    if ((c == q) || (c == CH_BSLASH) || ($urandom_range(0, 9) == 0))
                        add(CH_BSLASH, 1'b0);
                    add(c, 1'b0);
                end
                if ($urandom_range(0, 9) != 0)
                    add(q, 1'b0);
            end else if (r < 55) begin
                len = $urandom_range(1, 8);
                repeat (len) begin
                    do c = 8'($urandom_range(0, 255)); while (ends_bare(c));
                    add(c, 1'b0);
                end
            end else if (r < 70) begin
                len = $urandom_range(1, 3);
                repeat (len) begin
                    case ($urandom_range(0, 3))
                        0: add(CH_SPACE, 1'b0);
                        1: add(CH_TAB, 1'b0);
                        2: add(CH_CR, 1'b0);
                        default: add(CH_LF, 1'b0);
                    endcase
                end
            end else if (r < 77) begin
                add(CH_HASH, 1'b0);
                len = $urandom_range(0, 6);
                repeat (len) begin
                    do c = 8'($urandom_range(0, 255)); while (c == CH_LF);
                    add(c, 1'b0);
                end
                if ($urandom_range(0, 9) != 0)
                    add(CH_LF, 1'b0);
            end else if (r < 82) begin
                add(CH_COMMA, 1'b0);
            end else if (r < 86) begin
                add(8'($urandom_range(0, 255)), 1'b1);
            end else begin
                add(8'($urandom_range(0, 255)), 1'b0);
            end
        end
    endtask

    // Predict at the moment a word is taken.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            lex_word(s_in_byte, s_end_of_input);
            n_words++;
            if (s_end_of_input)
                n_eoi++;
            if (cur_word.n_res == PREDICT) begin
                foreach (step_q[j])
                    token_q.push_back(step_q[j]);
            end else begin
                if (cur_word.n_res >= 1)
                    token_q.push_back(cur_word.r0);
                if (cur_word.n_res == 2)
                    token_q.push_back(cur_word.r1);
            end
        end
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (m_kind == KIND_BYTE)
                n_bytes++;
            else if (m_kind == KIND_END)
                n_ends++;
            else
                n_punct++;
            if (token_q.size() == 0) begin
                $display("%0t: unexpected result, kind %0d byte %02h last %0b",
                         $time, m_kind, m_token_byte, m_last);
                errors++;
            end else begin
                want = token_q.pop_front();
                if (m_kind !== want.kind) begin
                    $display("%0t: kind mismatch, expected %0d, got %0d",
                             $time, want.kind, m_kind);
                    errors++;
                end
                if (m_token_byte !== want.token_byte) begin
                    $display("%0t: token_byte mismatch, expected %02h, got %02h",
                             $time, want.token_byte, m_token_byte);
                    errors++;
                end
                if (m_last !== want.last) begin
                    $display("%0t: last mismatch, expected %0b, got %0b",
                             $time, want.last, m_last);
                    errors++;
                end
            end
        end
    end

    // Result side: random stalls, with calm stretches now and then.
    always @(negedge aclk) begin
        if ($urandom_range(0, 299) == 0)
            sink_calm = !sink_calm;
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            stall_left = sink_calm ? 0 : pick_gap();
        end
    end

    initial begin
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        word_t w;
        int    gap;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_in_byte      = 8'h00;
        s_end_of_input = 1'b0;

        // Directed text: punctuation, byte extremes, quotes, escapes, comments
        // and end marks in each open state.
        text_q.push_back(row(CH_COLON, 1'b0, 1, KIND_COLON));
        text_q.push_back(row(CH_SEMI, 1'b0, 1, KIND_SEMI));
        text_q.push_back(row(CH_LBRACE, 1'b0, 1, KIND_LBR));
        text_q.push_back(row(CH_RBRACE, 1'b0, 1, KIND_RBR));
        text_q.push_back(row(8'h00, 1'b0, 1, KIND_BYTE, 8'h00));
        text_q.push_back(row(8'hFF, 1'b0, 1, KIND_BYTE, 8'hFF));
        text_q.push_back(row(CH_COMMA, 1'b0, 1, KIND_END));
        text_q.push_back(row(CH_DQUOTE, 1'b0, 0));
        text_q.push_back(row(CH_SQUOTE, 1'b0, 1, KIND_BYTE, CH_SQUOTE));
        text_q.push_back(row(CH_BSLASH, 1'b0, 0));
        text_q.push_back(row(CH_DQUOTE, 1'b0, PREDICT));
        text_q.push_back(row(CH_DQUOTE, 1'b0, 1, KIND_END));
        text_q.push_back(row(CH_SQUOTE, 1'b0, 0));
        text_q.push_back(row(CH_SQUOTE, 1'b0, 1, KIND_END));
        text_q.push_back(row("a", 1'b0, PREDICT));
        text_q.push_back(row(CH_SEMI, 1'b0, 2, KIND_END, 8'h00, KIND_SEMI));
        text_q.push_back(row("b", 1'b0, PREDICT));
        text_q.push_back(row(CH_HASH, 1'b0, 1, KIND_END));
        text_q.push_back(row("x", 1'b0, 0));
        text_q.push_back(row(CH_LF, 1'b0, 0));
        text_q.push_back(row("c", 1'b0, PREDICT));
        text_q.push_back(row(CH_DQUOTE, 1'b0, PREDICT));
        text_q.push_back(row(8'h5A, 1'b1, 1, KIND_END));
        text_q.push_back(row("d", 1'b0, PREDICT));
        text_q.push_back(row(8'h00, 1'b1, 1, KIND_END));
        text_q.push_back(row(CH_HASH, 1'b0, 0));
        text_q.push_back(row(8'hFF, 1'b1, 0));
        text_q.push_back(row(CH_SQUOTE, 1'b0, 0));
        text_q.push_back(row(CH_BSLASH, 1'b0, 0));
        text_q.push_back(row(8'h00, 1'b1, 1, KIND_END));
        build_random_text();

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < text_q.size(); i++) begin
            if (i % 100 == 0)
                drv_calm = ($urandom_range(0, 3) == 0);
            w   = text_q[i];
            gap = drv_calm ? 0 : pick_gap();
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            s_valid        <= 1'b1;
            s_in_byte      <= w.ch;
            s_end_of_input <= w.eoi;
            cur_word       <= w;
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
            @(negedge aclk);
        end
        s_valid <= 1'b0;

        while (token_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("tb: lexed %0d words including %0d end marks, with random stalls both sides",
                 n_words, n_eoi);
        $display("tb: saw %0d string bytes, %0d string ends and %0d punctuation tokens",
                 n_bytes, n_ends, n_punct);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
